### hdl/qhft_pkg.sv
package qhft_pkg;

   localparam int TableEntries = 64;
   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = 32;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      OP_SEEN    = 2'd0,
      OP_ROUTE   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE          = 3'd0,
      ST_FORWARD       = 3'd1,
      ST_DROP_FLOWC    = 3'd2,
      ST_DROP_THROTTLE = 3'd3,
      ST_NOT_WRITABLE  = 3'd4,
      ST_UNKNOWN       = 3'd5,
      ST_FULL          = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_HALF_LIFE = 2'd0,
      CSR_MIN_HITS  = 2'd1,
      CSR_POPULAR   = 2'd2,
      CSR_MAX_HITS  = 2'd3
   } csr_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] id_high;
      logic [63:0] id_low;
      logic [7:0]  hit_count;
      logic        swift_mode;
      logic        flow_controlled;
      logic        bytes_over_high;
      logic        bytes_over_low;
      logic        was_sent;
      logic [31:0] now_seconds;
      logic        not_writable;
   } cmd_type;

   function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                               input logic [CntW-1:0] b);
      logic [CntW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
   endfunction

endpackage

### hdl/query_hit_flow_throttle.sv
// Query hit flow throttle.
// Request channel (req_*): one transaction per event, accepted when
// req_valid is high and req_stall low. op selects results seen, route,
// release or timer tick; the other fields carry the message ID, hit count,
// destination queue state and time.
// Response channel (rsp_*): exactly one transaction per request, in order,
// with rsp_status and rsp_rotated; held stable while rsp_stall is high.
// Configuration: csr_write with csr_index and csr_data sets half life,
// min, popular and max hit thresholds; write only while idle.
// A front stage classifies requests into a two-entry queue; the back
// engine scans the 64-entry table one entry at a time, each through a
// scan state and a read state for the registered key memory read. A
// lookup stops at a matching entry and a miss scans the whole table;
// ticks and unwritable routes skip the scan and respond directly.
// Reset clears every entry valid bit and the generation state at once and
// loads the default thresholds; no clearing pass is needed.
// A stalled response holds the engine; the queue keeps taking requests
// until it is full, then req_stall rises.
module query_hit_flow_throttle (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_id_high,
   input  logic [63:0] req_id_low,
   input  logic [7:0]  req_hit_count,
   input  logic        req_dest_writable,
   input  logic        req_swift_mode,
   input  logic        req_flow_controlled,
   input  logic [31:0] req_queue_bytes,
   input  logic [31:0] req_queue_high_mark,
   input  logic [31:0] req_queue_low_mark,
   input  logic        req_was_sent,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_rotated,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import qhft_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid, cmd_pop;

   qhft_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_id_high, .req_id_low,
      .req_hit_count, .req_dest_writable, .req_swift_mode, .req_flow_controlled,
      .req_queue_bytes, .req_queue_high_mark, .req_queue_low_mark, .req_was_sent,
      .req_now_seconds, .cmd_data, .cmd_valid, .cmd_pop
   );

   qhft_back u_back (
      .clock, .reset, .cmd_data, .cmd_valid, .cmd_pop, .csr_write, .csr_index,
      .csr_data, .rsp_valid, .rsp_stall, .rsp_status, .rsp_rotated
   );

endmodule

### hdl/qhft_front.sv
module qhft_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_id_high,
   input  logic [63:0]         req_id_low,
   input  logic [7:0]          req_hit_count,
   input  logic                req_dest_writable,
   input  logic                req_swift_mode,
   input  logic                req_flow_controlled,
   input  logic [31:0]         req_queue_bytes,
   input  logic [31:0]         req_queue_high_mark,
   input  logic [31:0]         req_queue_low_mark,
   input  logic                req_was_sent,
   input  logic [31:0]         req_now_seconds,
   output qhft_pkg::cmd_type   cmd_data,
   output logic                cmd_valid,
   input  logic                cmd_pop
);
   import qhft_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type           q_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]     cnt_ff, cnt_in;
   cmd_type           cmd_new;
   logic              push;

   always_comb begin
      cmd_new.op              = op_type'(req_op);
      cmd_new.id_high         = req_id_high;
      cmd_new.id_low          = req_id_low;
      cmd_new.hit_count       = req_hit_count;
      cmd_new.swift_mode      = req_swift_mode;
      cmd_new.flow_controlled = req_flow_controlled;
      cmd_new.bytes_over_high = req_queue_bytes > req_queue_high_mark;
      cmd_new.bytes_over_low  = req_queue_bytes > req_queue_low_mark;
      cmd_new.was_sent        = req_was_sent;
      cmd_new.now_seconds     = req_now_seconds;
      cmd_new.not_writable    = !req_dest_writable;
   end

   assign req_stall = (cnt_ff == PtrW'(0) + (PtrW+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = cmd_pop ? ((rd_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cmd_new;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PtrW+1)'(QueueDepth)) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> cnt_ff != '0) else $error("full queue drained too far");

endmodule

### hdl/qhft_back.sv
module qhft_back (
   input  logic                clock,
   input  logic                reset,
   input  qhft_pkg::cmd_type   cmd_data,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic                rsp_rotated
);
   import qhft_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_EXEC, S_WRITE, S_OUT
   } state_type;

   state_type          state_ff;
   logic [IdxW-1:0]    scan_ff;
   logic               found_ff, free_ok_ff;
   logic [IdxW-1:0]    hit_idx_ff, free_idx_ff;
   logic [TableEntries-1:0] valid_ff, gen_ff;
   logic               cur_gen_ff;
   logic [31:0]        last_rot_ff;
   logic [15:0]        half_life_ff, min_hits_ff, popular_ff, max_hits_ff;
   logic [2:0]         status_ff;
   logic               rotated_ff;
   cmd_type            cmd_ff;

   logic [63:0]        key_hi_mem [TableEntries];
   logic [63:0]        key_lo_mem [TableEntries];
   logic [CntW-1:0]    msg_mem [TableEntries];
   logic [CntW-1:0]    recv_mem [TableEntries];
   logic [CntW-1:0]    sent_mem [TableEntries];
   logic [CntW-1:0]    queued_mem [TableEntries];

   logic [63:0]        khi_rd_ff, klo_rd_ff;
   logic [CntW-1:0]    msg_rd_ff, recv_rd_ff, sent_rd_ff, queued_rd_ff;
   logic [CntW-1:0]    msg_in, recv_in, sent_in, queued_in;
   logic               new_ff;
   logic [IdxW-1:0]    ent_ff;

   logic [15:0]        margin;
   logic [31:0]        diff;
   logic               rotate_now;
   logic [2:0]         decision;
   logic               key_match;
   logic [CntW-1:0]    q_minus;

   assign cmd_pop     = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_status  = status_ff;
   assign rsp_rotated = rotated_ff;

   assign margin     = (popular_ff > min_hits_ff) ? popular_ff - min_hits_ff : '0;
   assign diff       = cmd_data.now_seconds - last_rot_ff;
   assign rotate_now = (cmd_data.op == OP_TICK) && !diff[31] && diff >= 32'(half_life_ff);
   assign key_match  = valid_ff[scan_ff] && khi_rd_ff == cmd_ff.id_high
                       && klo_rd_ff == cmd_ff.id_low;
   assign q_minus    = (queued_rd_ff > CntW'(cmd_ff.hit_count))
                       ? queued_rd_ff - CntW'(cmd_ff.hit_count) : '0;

   always_comb begin
      priority if (cmd_ff.swift_mode && (sent_rd_ff != '0 || queued_rd_ff != '0))
         decision = ST_DROP_FLOWC;
      else if (cmd_ff.flow_controlled && queued_rd_ff != '0)
         decision = ST_DROP_FLOWC;
      else if (sent_rd_ff >= CntW'(min_hits_ff) && cmd_ff.bytes_over_high)
         decision = ST_DROP_FLOWC;
      else if (sent_rd_ff >= CntW'(popular_ff) && cmd_ff.bytes_over_low)
         decision = ST_DROP_FLOWC;
      else if (sent_rd_ff >= CntW'(min_hits_ff) && recv_rd_ff >= CntW'(popular_ff)
               && queued_rd_ff >= CntW'(margin))
         decision = ST_DROP_THROTTLE;
      else if (sent_rd_ff >= CntW'(popular_ff) && queued_rd_ff >= CntW'(min_hits_ff))
         decision = ST_DROP_THROTTLE;
      else if (sent_rd_ff >= CntW'(max_hits_ff) && queued_rd_ff != '0)
         decision = ST_DROP_THROTTLE;
      else
         decision = ST_FORWARD;
   end

   always_comb begin
      msg_in    = new_ff ? '0 : msg_rd_ff;
      recv_in   = new_ff ? '0 : recv_rd_ff;
      sent_in   = new_ff ? '0 : sent_rd_ff;
      queued_in = new_ff ? '0 : queued_rd_ff;
      unique case (cmd_ff.op)
         OP_SEEN: begin
            msg_in  = sat_add(msg_in, CntW'(1));
            recv_in = sat_add(recv_in, CntW'(cmd_ff.hit_count));
         end
         OP_ROUTE: begin
            if (decision == ST_FORWARD) begin
               queued_in = sat_add(queued_rd_ff, CntW'(cmd_ff.hit_count));
            end
         end
         OP_RELEASE: begin
            queued_in = q_minus;
            if (cmd_ff.was_sent) begin
               sent_in = sat_add(sent_rd_ff, CntW'(cmd_ff.hit_count));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      khi_rd_ff    <= key_hi_mem[scan_ff];
      klo_rd_ff    <= key_lo_mem[scan_ff];
      msg_rd_ff    <= msg_mem[ent_ff];
      recv_rd_ff   <= recv_mem[ent_ff];
      sent_rd_ff   <= sent_mem[ent_ff];
      queued_rd_ff <= queued_mem[ent_ff];
      if (state_ff == S_WRITE) begin
         msg_mem[ent_ff]    <= msg_in;
         recv_mem[ent_ff]   <= recv_in;
         sent_mem[ent_ff]   <= sent_in;
         queued_mem[ent_ff] <= queued_in;
         if (new_ff) begin
            key_hi_mem[ent_ff] <= cmd_ff.id_high;
            key_lo_mem[ent_ff] <= cmd_ff.id_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         gen_ff       <= '0;
         cur_gen_ff   <= 1'b0;
         last_rot_ff  <= '0;
         half_life_ff <= 16'd300;
         min_hits_ff  <= 16'd250;
         popular_ff   <= 16'd500;
         max_hits_ff  <= 16'd1000;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         hit_idx_ff   <= '0;
         free_idx_ff  <= '0;
         ent_ff       <= '0;
         new_ff       <= 1'b0;
         status_ff    <= ST_DONE;
         rotated_ff   <= 1'b0;
         cmd_ff       <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_type'(csr_index))
               CSR_HALF_LIFE: half_life_ff <= csr_data;
               CSR_MIN_HITS:  min_hits_ff  <= csr_data;
               CSR_POPULAR:   popular_ff   <= csr_data;
               CSR_MAX_HITS:  max_hits_ff  <= csr_data;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff     <= cmd_data;
                  scan_ff    <= '0;
                  found_ff   <= 1'b0;
                  free_ok_ff <= 1'b0;
                  new_ff     <= 1'b0;
                  rotated_ff <= rotate_now;
                  if (rotate_now) begin
                     valid_ff    <= valid_ff & ~(gen_ff ^ {TableEntries{cur_gen_ff}});
                     cur_gen_ff  <= !cur_gen_ff;
                     last_rot_ff <= cmd_data.now_seconds;
                  end
                  if (cmd_data.op == OP_TICK) begin
                     status_ff <= ST_DONE;
                     state_ff  <= S_OUT;
                  end else if (cmd_data.op == OP_ROUTE && cmd_data.not_writable) begin
                     status_ff <= ST_NOT_WRITABLE;
                     state_ff  <= S_OUT;
                  end else begin
                     status_ff <= ST_DONE;
                     state_ff  <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // key read for scan_ff arrives next cycle
               state_ff <= S_READ;
            end
            S_READ: begin
               if (key_match && !found_ff) begin
                  found_ff   <= 1'b1;
                  hit_idx_ff <= scan_ff;
               end
               if (!valid_ff[scan_ff] && !free_ok_ff) begin
                  free_ok_ff  <= 1'b1;
                  free_idx_ff <= scan_ff;
               end
               if (key_match || scan_ff == IdxW'(TableEntries-1)) begin
                  state_ff <= S_EXEC;
                  if (key_match) begin
                     ent_ff <= scan_ff;
                  end else if (found_ff) begin
                     ent_ff <= hit_idx_ff;
                  end else if (!valid_ff[scan_ff] && !free_ok_ff) begin
                     ent_ff <= scan_ff;
                  end else begin
                     ent_ff <= free_idx_ff;
                  end
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_EXEC: begin
               // counters for ent_ff are registered at the end of this cycle
               if (!found_ff) begin
                  if (cmd_ff.op != OP_SEEN) begin
                     status_ff <= ST_UNKNOWN;
                     state_ff  <= S_OUT;
                  end else if (!free_ok_ff) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_OUT;
                  end else begin
                     new_ff           <= 1'b1;
                     valid_ff[ent_ff] <= 1'b1;
                     gen_ff[ent_ff]   <= cur_gen_ff;
                     state_ff         <= S_WRITE;
                  end
               end else begin
                  gen_ff[ent_ff] <= cur_gen_ff;
                  state_ff       <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (cmd_ff.op == OP_ROUTE) begin
                  status_ff <= decision;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");
   a_rot_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rotated |-> cmd_ff.op == OP_TICK)
      else $error("rotation outside tick");
   a_new_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE && new_ff |-> valid_ff[ent_ff])
      else $error("new entry not marked valid");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff != S_IDLE)
      else $error("pop without work");

endmodule
